/* rtl/core/csma_pkg.sv */
// Package for the CSMA-CA retry latency accountant.
// Holds the beat, command and configuration types and the shared constants.
// Depends on nothing; all other files of the block refer to it by scoped names.
package csma_pkg;

  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned AccumW      = 32;
  localparam int unsigned LatW        = 42;
  localparam int unsigned FixW        = 18;
  localparam int unsigned BoW         = 24;
  localparam int unsigned NsPerUs     = 1000;
  localparam int unsigned MidDepth    = 2;
  localparam int unsigned MidCntW     = 2;
  localparam int unsigned OutDepth    = 4;
  localparam int unsigned OutPtrW     = 2;
  localparam int unsigned OutCntW     = 3;
  localparam int unsigned AddrW       = 5;
  localparam int unsigned DataW       = 32;

  localparam logic [1:0] CauseNone   = 2'd0;
  localparam logic [1:0] CauseAccess = 2'd1;
  localparam logic [1:0] CauseNoAck  = 2'd2;

  typedef enum logic [1:0] {
    KIND_BUSY  = 2'd0,
    KIND_RETRY = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_MIN_BE       = 3'd0,
    REG_MAX_BE       = 3'd1,
    REG_MAX_BACKOFFS = 3'd2,
    REG_MAX_RETRIES  = 3'd3,
    REG_BACKOFF_UNIT = 3'd4,
    REG_CCA_TIME     = 3'd5,
    REG_BYTE_TIME    = 3'd6,
    REG_ACK_WAIT     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [3:0]  min_backoff_exp;
    logic [3:0]  max_backoff_exp;
    logic [2:0]  max_csma_backoffs;
    logic [2:0]  max_frame_retries;
    logic [15:0] backoff_unit_us;
    logic [15:0] cca_time_us;
    logic [7:0]  byte_time_us;
    logic [15:0] ack_wait_us;
  } cfg_t;

  typedef struct packed {
    logic [7:0] backoff_draw;
    logic       channel_busy;
    logic       ack_lost;
    logic [6:0] packet_size;
  } in_t;

  typedef struct packed {
    logic [LatW-1:0] latency_ns;
    logic            lost;
    logic [1:0]      loss_cause;
  } out_t;

  typedef struct packed {
    logic [7:0]      draw;
    kind_e           kind;
    logic [FixW-1:0] fix_us;
  } cmd_t;

  typedef struct packed {
    logic       we;
    logic [3:0] value;
  } min_wr_t;

endpackage

/* rtl/core/csma_front.sv */
// Front end of the CSMA-CA latency accountant: accepts input beats, classifies them
// and precomputes the state-independent time, then queues them for the back end.
// Depends on csma_pkg.
module csma_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csma_pkg::cfg_t     cfg_i,
  input  logic               push,
  output logic               full,
  input  csma_pkg::in_t      item_i,
  output logic               cmd_valid_o,
  output csma_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  csma_pkg::cmd_t                      mem_q [csma_pkg::MidDepth];
  logic                                wr_ptr_q, wr_ptr_d;
  logic                                rd_ptr_q, rd_ptr_d;
  logic [csma_pkg::MidCntW-1:0]        cnt_q, cnt_d;
  logic                                do_push;
  logic                                do_pop;
  logic [7:0]                          bytes;
  logic [15:0]                         tx_us;
  logic [csma_pkg::FixW-1:0]           fix_us;
  csma_pkg::kind_e                     kind;
  csma_pkg::cmd_t                      wr_cmd;

  always_comb begin
    bytes = 8'(item_i.packet_size) + 8'(csma_pkg::HeaderBytes);
    tx_us = 16'(bytes) * 16'(cfg_i.byte_time_us);
    if (item_i.channel_busy) begin
      kind   = csma_pkg::KIND_BUSY;
      fix_us = csma_pkg::FixW'(cfg_i.cca_time_us);
    end else begin
      kind   = item_i.ack_lost ? csma_pkg::KIND_RETRY : csma_pkg::KIND_DONE;
      fix_us = csma_pkg::FixW'(cfg_i.cca_time_us) + csma_pkg::FixW'(tx_us)
             + csma_pkg::FixW'(cfg_i.ack_wait_us);
    end
    wr_cmd.draw   = item_i.backoff_draw;
    wr_cmd.kind   = kind;
    wr_cmd.fix_us = fix_us;
  end

  assign full        = (cnt_q == csma_pkg::MidCntW'(csma_pkg::MidDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + csma_pkg::MidCntW'(do_push) - csma_pkg::MidCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_cmd;
    end
  end

endmodule

/* rtl/core/csma_back.sv */
// Back end of the CSMA-CA latency accountant: per-packet state update for one
// command a cycle while the result queue has room, and conversion of a finished
// packet's time to nanoseconds. Depends on csma_pkg.
module csma_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csma_pkg::cfg_t                cfg_i,
  input  csma_pkg::min_wr_t             min_wr_i,
  input  logic                          cmd_valid_i,
  input  csma_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  input  logic [csma_pkg::OutCntW-1:0]  out_cnt_i,
  output logic                          res_valid_o,
  output csma_pkg::out_t                res_o
);

  logic [3:0]                   be_q, be_d;
  logic [2:0]                   busy_cnt_q, busy_cnt_d;
  logic [2:0]                   retry_q, retry_d;
  logic [csma_pkg::AccumW-1:0]  accum_q, accum_d;
  logic                         in_pkt_q, in_pkt_d;
  logic                         fin_valid_q, fin_valid_d;
  logic [csma_pkg::AccumW-1:0]  fin_accum_q, fin_accum_d;
  logic [1:0]                   fin_cause_q, fin_cause_d;
  logic                         fire;
  logic [7:0]                   mask;
  logic [csma_pkg::BoW-1:0]     bo_us;
  logic [csma_pkg::AccumW+1:0]  sum;
  logic [csma_pkg::AccumW-1:0]  acc_sat;
  logic                         finish;
  logic [1:0]                   cause;

  assign fire = cmd_valid_i &&
                ((csma_pkg::OutCntW+1)'(out_cnt_i) + (csma_pkg::OutCntW+1)'(fin_valid_q)
                 < (csma_pkg::OutCntW+1)'(csma_pkg::OutDepth));
  assign cmd_pop_o = fire;

  always_comb begin
    mask    = (be_q >= 4'd8) ? 8'hFF : ~(8'hFF << be_q[2:0]);
    bo_us   = csma_pkg::BoW'(cmd_i.draw & mask) * csma_pkg::BoW'(cfg_i.backoff_unit_us);
    sum     = (csma_pkg::AccumW+2)'(accum_q) + (csma_pkg::AccumW+2)'(bo_us)
            + (csma_pkg::AccumW+2)'(cmd_i.fix_us);
    acc_sat = (sum[csma_pkg::AccumW+1:csma_pkg::AccumW] != 2'd0) ? '1
            : sum[csma_pkg::AccumW-1:0];

    be_d       = be_q;
    busy_cnt_d = busy_cnt_q;
    retry_d    = retry_q;
    accum_d    = accum_q;
    in_pkt_d   = in_pkt_q;
    finish     = 1'b0;
    cause      = csma_pkg::CauseNone;

    if (fire) begin
      in_pkt_d = 1'b1;
      accum_d  = acc_sat;
      unique case (cmd_i.kind)
        csma_pkg::KIND_BUSY: begin
          if (be_q < cfg_i.max_backoff_exp) begin
            be_d = be_q + 4'd1;
          end
          if (busy_cnt_q >= cfg_i.max_csma_backoffs) begin
            finish = 1'b1;
            cause  = csma_pkg::CauseAccess;
          end else begin
            busy_cnt_d = busy_cnt_q + 3'd1;
          end
        end
        csma_pkg::KIND_RETRY: begin
          if (retry_q >= cfg_i.max_frame_retries) begin
            finish = 1'b1;
            cause  = csma_pkg::CauseNoAck;
          end else begin
            retry_d    = retry_q + 3'd1;
            be_d       = cfg_i.min_backoff_exp;
            busy_cnt_d = 3'd0;
          end
        end
        csma_pkg::KIND_DONE: begin
          finish = 1'b1;
        end
        default: begin
          finish = 1'b1;
        end
      endcase
      if (finish) begin
        be_d       = cfg_i.min_backoff_exp;
        busy_cnt_d = 3'd0;
        retry_d    = 3'd0;
        accum_d    = '0;
        in_pkt_d   = 1'b0;
      end
    end else if (min_wr_i.we && !in_pkt_q) begin
      be_d = min_wr_i.value;
    end

    fin_valid_d = fire && finish;
    fin_accum_d = acc_sat;
    fin_cause_d = cause;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      be_q        <= 4'd3;
      busy_cnt_q  <= 3'd0;
      retry_q     <= 3'd0;
      accum_q     <= '0;
      in_pkt_q    <= 1'b0;
      fin_valid_q <= 1'b0;
    end else begin
      be_q        <= be_d;
      busy_cnt_q  <= busy_cnt_d;
      retry_q     <= retry_d;
      accum_q     <= accum_d;
      in_pkt_q    <= in_pkt_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid_d) begin
      fin_accum_q <= fin_accum_d;
      fin_cause_q <= fin_cause_d;
    end
  end

  always_comb begin
    res_valid_o      = fin_valid_q;
    res_o.latency_ns = csma_pkg::LatW'(fin_accum_q)
                     * csma_pkg::LatW'(10'(csma_pkg::NsPerUs));
    res_o.lost       = (fin_cause_q != csma_pkg::CauseNone);
    res_o.loss_cause = fin_cause_q;
  end

endmodule

/* rtl/core/csma_outq.sv */
// Result queue of the CSMA-CA latency accountant: holds finished result beats
// until the receiver pops them. Depends on csma_pkg.
module csma_outq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  input  csma_pkg::out_t                res_i,
  output logic [csma_pkg::OutCntW-1:0]  cnt_o,
  output logic                          empty,
  input  logic                          pop,
  output csma_pkg::out_t                result_o
);

  csma_pkg::out_t                 mem_q [csma_pkg::OutDepth];
  logic [csma_pkg::OutPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [csma_pkg::OutPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [csma_pkg::OutCntW-1:0]   cnt_q, cnt_d;
  logic                           do_pop;

  assign empty    = (cnt_q == '0);
  assign cnt_o    = cnt_q;
  assign result_o = mem_q[rd_ptr_q];
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_d = res_valid_i ? wr_ptr_q + csma_pkg::OutPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + csma_pkg::OutPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + csma_pkg::OutCntW'(res_valid_i) - csma_pkg::OutCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

/* rtl/core/csma_ca_retry_latency.sv */
// Top level of the CSMA-CA retry latency accountant with its configuration registers.
// Instantiates csma_front, csma_back and csma_outq; depends on csma_pkg.
//
// Usage: each input beat is one channel-access attempt of the current packet,
// written with push while full is low. A packet ends on a delivery, on too many
// busy backoffs or on too many lost acks; then one result beat with the latency
// in nanoseconds and the loss cause appears, read with pop while empty is low.
// Attempts that do not end a packet give no result.
// Throughput is one beat per cycle while the result queue has room: the back end
// updates exponent, counters and the saturating microsecond accumulator for one
// attempt combinationally, and that loop sets the rate. The result of a finishing
// beat passes the command queue, then the finish register and nanosecond multiply.
// When the receiver stalls, up to four results wait in the result queue; the
// back end then holds, the two-entry command queue fills and full rises.
// Reset empties both queues, returns the registers to their defaults and clears
// the packet state. Registers are written over the APB port at byte address
// 4*index and are meant to be written only while the block is idle.
module csma_ca_retry_latency (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csma_pkg::AddrW-1:0]    paddr,
  input  logic [csma_pkg::DataW-1:0]    pwdata,
  output logic [csma_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  csma_pkg::in_t                 item_i,
  output logic                          empty,
  input  logic                          pop,
  output csma_pkg::out_t                result_o
);

  csma_pkg::cfg_t                       cfg_q, cfg_d;
  csma_pkg::min_wr_t                    min_wr;
  csma_pkg::reg_idx_e                   reg_idx;
  logic                                 cfg_we;
  logic                                 cmd_valid;
  csma_pkg::cmd_t                       cmd;
  logic                                 cmd_pop;
  logic [csma_pkg::OutCntW-1:0]         out_cnt;
  logic                                 res_valid;
  csma_pkg::out_t                       res;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = csma_pkg::reg_idx_e'(paddr[csma_pkg::AddrW-1:2]);

  always_comb begin
    cfg_d        = cfg_q;
    min_wr.we    = 1'b0;
    min_wr.value = pwdata[3:0];
    if (cfg_we) begin
      unique case (reg_idx)
        csma_pkg::REG_MIN_BE: begin
          cfg_d.min_backoff_exp = pwdata[3:0];
          min_wr.we             = 1'b1;
        end
        csma_pkg::REG_MAX_BE:       cfg_d.max_backoff_exp   = pwdata[3:0];
        csma_pkg::REG_MAX_BACKOFFS: cfg_d.max_csma_backoffs = pwdata[2:0];
        csma_pkg::REG_MAX_RETRIES:  cfg_d.max_frame_retries = pwdata[2:0];
        csma_pkg::REG_BACKOFF_UNIT: cfg_d.backoff_unit_us   = pwdata[15:0];
        csma_pkg::REG_CCA_TIME:     cfg_d.cca_time_us       = pwdata[15:0];
        csma_pkg::REG_BYTE_TIME:    cfg_d.byte_time_us      = pwdata[7:0];
        csma_pkg::REG_ACK_WAIT:     cfg_d.ack_wait_us       = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      csma_pkg::REG_MIN_BE:       prdata = csma_pkg::DataW'(cfg_q.min_backoff_exp);
      csma_pkg::REG_MAX_BE:       prdata = csma_pkg::DataW'(cfg_q.max_backoff_exp);
      csma_pkg::REG_MAX_BACKOFFS: prdata = csma_pkg::DataW'(cfg_q.max_csma_backoffs);
      csma_pkg::REG_MAX_RETRIES:  prdata = csma_pkg::DataW'(cfg_q.max_frame_retries);
      csma_pkg::REG_BACKOFF_UNIT: prdata = csma_pkg::DataW'(cfg_q.backoff_unit_us);
      csma_pkg::REG_CCA_TIME:     prdata = csma_pkg::DataW'(cfg_q.cca_time_us);
      csma_pkg::REG_BYTE_TIME:    prdata = csma_pkg::DataW'(cfg_q.byte_time_us);
      csma_pkg::REG_ACK_WAIT:     prdata = csma_pkg::DataW'(cfg_q.ack_wait_us);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_backoff_exp   <= 4'd3;
      cfg_q.max_backoff_exp   <= 4'd5;
      cfg_q.max_csma_backoffs <= 3'd4;
      cfg_q.max_frame_retries <= 3'd3;
      cfg_q.backoff_unit_us   <= 16'd320;
      cfg_q.cca_time_us       <= 16'd128;
      cfg_q.byte_time_us      <= 8'd32;
      cfg_q.ack_wait_us       <= 16'd864;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  csma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  csma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .min_wr_i    (min_wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_cnt_i   (out_cnt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  csma_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .cnt_o       (out_cnt),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt <= csma_pkg::OutCntW'(csma_pkg::OutDepth))
    else $error("Result queue holds more beats than its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (out_cnt == csma_pkg::OutCntW'(csma_pkg::OutDepth)) |-> pop)
    else $error("Result beat pushed into a full result queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("Back end took a command from an empty command queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.lost == (result_o.loss_cause != csma_pkg::CauseNone)))
    else $error("Lost flag disagrees with the loss cause.");

endmodule

/* verif/csma_ca_retry_latency_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for csma_ca_retry_latency: a directed table, then random attempt beats
// under several register settings, checked against an in-bench latency accountant.
// Depends on csma_pkg and the csma_ca_retry_latency RTL only.
module csma_ca_retry_latency_test;

  typedef struct packed {
    csma_pkg::in_t  beat;
    bit             known;
    csma_pkg::out_t want;
  } dir_row_t;

  localparam csma_pkg::out_t NoRes = '0;

  // Rows with a typed-in result run at the reset register values.
  localparam dir_row_t DirTable [18] = '{
    '{'{8'h00, 1'b0, 1'b0, 7'd0},   1'b1, '{42'd1184000, 1'b0, csma_pkg::CauseNone}},
    '{'{8'hFF, 1'b0, 1'b0, 7'd127}, 1'b1, '{42'd7488000, 1'b0, csma_pkg::CauseNone}},
    '{'{8'h00, 1'b1, 1'b1, 7'd0},   1'b0, NoRes},
    '{'{8'h00, 1'b1, 1'b1, 7'd127}, 1'b0, NoRes},
    '{'{8'h00, 1'b1, 1'b0, 7'd0},   1'b0, NoRes},
    '{'{8'h00, 1'b1, 1'b1, 7'd64},  1'b0, NoRes},
    '{'{8'h00, 1'b1, 1'b0, 7'd0},   1'b1, '{42'd640000, 1'b1, csma_pkg::CauseAccess}},
    '{'{8'h00, 1'b0, 1'b1, 7'd0},   1'b0, NoRes},
    '{'{8'h00, 1'b0, 1'b1, 7'd0},   1'b0, NoRes},
    '{'{8'h00, 1'b0, 1'b1, 7'd0},   1'b0, NoRes},
    '{'{8'h00, 1'b0, 1'b1, 7'd0},   1'b1, '{42'd4736000, 1'b1, csma_pkg::CauseNoAck}},
    '{'{8'hFF, 1'b1, 1'b0, 7'd50},  1'b0, NoRes},
    '{'{8'hFF, 1'b1, 1'b1, 7'd50},  1'b0, NoRes},
    '{'{8'hFF, 1'b1, 1'b0, 7'd50},  1'b0, NoRes},
    '{'{8'hAA, 1'b0, 1'b1, 7'd127}, 1'b0, NoRes},
    '{'{8'h55, 1'b1, 1'b0, 7'd3},   1'b0, NoRes},
    '{'{8'hFF, 1'b0, 1'b0, 7'd1},   1'b0, NoRes},
    '{'{8'h80, 1'b0, 1'b0, 7'd64},  1'b0, NoRes}
  };

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [csma_pkg::AddrW-1:0] paddr  = '0;
  logic [csma_pkg::DataW-1:0] pwdata = '0;
  logic [csma_pkg::DataW-1:0] prdata;
  logic        pready;
  logic        push    = 1'b0;
  logic        full;
  csma_pkg::in_t  beat_in = '0;
  logic        empty;
  logic        pop     = 1'b0;
  csma_pkg::out_t beat_out;

  bit             lit_known = 1'b0;
  csma_pkg::out_t lit_want  = '0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned fails     = 0;

  csma_pkg::cfg_t cfg_sh;
  logic [3:0]  acc_be;
  logic [2:0]  acc_busy;
  logic [2:0]  acc_retry;
  logic [31:0] acc_us;
  bit          acc_open;
  csma_pkg::out_t latency_reports_due [$];

  csma_ca_retry_latency dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .full     (full),
    .item_i   (beat_in),
    .empty    (empty),
    .pop      (pop),
    .result_o (beat_out)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void add_us(input logic [63:0] v);
    logic [64:0] s;
    s = acc_us + v;
    acc_us = (s > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit close_packet(input logic [1:0] cause, output csma_pkg::out_t r);
    logic [63:0] ns;
    ns = {32'd0, acc_us} * csma_pkg::NsPerUs;
    r.latency_ns = ns[csma_pkg::LatW-1:0];
    r.lost       = (cause != csma_pkg::CauseNone);
    r.loss_cause = cause;
    acc_be    = cfg_sh.min_backoff_exp;
    acc_busy  = '0;
    acc_retry = '0;
    acc_us    = '0;
    acc_open  = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit account_attempt(input csma_pkg::in_t b, output csma_pkg::out_t r);
    logic [7:0]  mask;
    logic [63:0] units;
    logic [63:0] bytes;
    r = '0;
    acc_open = 1'b1;
    mask = (acc_be >= 4'd8) ? 8'hFF : 8'((16'd1 << acc_be) - 16'd1);
    units = b.backoff_draw & mask;
    add_us(units * cfg_sh.backoff_unit_us);
    add_us(64'(cfg_sh.cca_time_us));
    if (b.channel_busy) begin
      if (acc_be < cfg_sh.max_backoff_exp) acc_be = acc_be + 4'd1;
      if (acc_busy >= cfg_sh.max_csma_backoffs) begin
        return close_packet(csma_pkg::CauseAccess, r);
      end
      acc_busy = acc_busy + 3'd1;
      return 1'b0;
    end
    bytes = b.packet_size + csma_pkg::HeaderBytes;
    add_us(bytes * cfg_sh.byte_time_us);
    add_us(64'(cfg_sh.ack_wait_us));
    if (b.ack_lost) begin
      if (acc_retry >= cfg_sh.max_frame_retries) begin
        return close_packet(csma_pkg::CauseNoAck, r);
      end
      acc_retry = acc_retry + 3'd1;
      acc_be    = cfg_sh.min_backoff_exp;
      acc_busy  = '0;
      return 1'b0;
    end
    return close_packet(csma_pkg::CauseNone, r);
  endfunction

  always @(posedge clk_i) begin
    csma_pkg::out_t predicted;
    csma_pkg::out_t want;
    bit   hit;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (latency_reports_due.size() == 0) begin
          $error("result beat with no expectation: latency_ns %0d", beat_out.latency_ns);
          fails++;
        end else begin
          want = latency_reports_due.pop_front();
          if (beat_out.latency_ns !== want.latency_ns) begin
            $error("latency_ns: expected %0d, actual %0d", want.latency_ns, beat_out.latency_ns);
            fails++;
          end
          if (beat_out.lost !== want.lost) begin
            $error("lost: expected %0d, actual %0d", want.lost, beat_out.lost);
            fails++;
          end
          if (beat_out.loss_cause !== want.loss_cause) begin
            $error("loss_cause: expected %0d, actual %0d", want.loss_cause, beat_out.loss_cause);
            fails++;
          end
        end
      end
      if (push && !full) begin
        hit = account_attempt(beat_in, predicted);
        if (lit_known) latency_reports_due.push_back(lit_want);
        else if (hit) latency_reports_due.push_back(predicted);
      end
    end
  end

  // Receiver side: a long hold-off when asked, else random stalls.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      pop = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic program_reg(input csma_pkg::reg_idx_e idx, input logic [31:0] v);
    logic [31:0] want;
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    want = '0;
    case (idx)
      csma_pkg::REG_MIN_BE: begin
        cfg_sh.min_backoff_exp = v[3:0];
        want = v[3:0];
        if (!acc_open) acc_be = v[3:0];
      end
      csma_pkg::REG_MAX_BE: begin
        cfg_sh.max_backoff_exp = v[3:0];
        want = v[3:0];
      end
      csma_pkg::REG_MAX_BACKOFFS: begin
        cfg_sh.max_csma_backoffs = v[2:0];
        want = v[2:0];
      end
      csma_pkg::REG_MAX_RETRIES: begin
        cfg_sh.max_frame_retries = v[2:0];
        want = v[2:0];
      end
      csma_pkg::REG_BACKOFF_UNIT: begin
        cfg_sh.backoff_unit_us = v[15:0];
        want = v[15:0];
      end
      csma_pkg::REG_CCA_TIME: begin
        cfg_sh.cca_time_us = v[15:0];
        want = v[15:0];
      end
      csma_pkg::REG_BYTE_TIME: begin
        cfg_sh.byte_time_us = v[7:0];
        want = v[7:0];
      end
      csma_pkg::REG_ACK_WAIT: begin
        cfg_sh.ack_wait_us = v[15:0];
        want = v[15:0];
      end
    endcase
    if (got !== want) begin
      $error("register %s: expected %0h, actual %0h", idx.name(), want, got);
      fails++;
    end
  endtask

  task automatic load_cfg(input csma_pkg::cfg_t c);
    program_reg(csma_pkg::REG_MIN_BE,       32'(c.min_backoff_exp));
    program_reg(csma_pkg::REG_MAX_BE,       32'(c.max_backoff_exp));
    program_reg(csma_pkg::REG_MAX_BACKOFFS, 32'(c.max_csma_backoffs));
    program_reg(csma_pkg::REG_MAX_RETRIES,  32'(c.max_frame_retries));
    program_reg(csma_pkg::REG_BACKOFF_UNIT, 32'(c.backoff_unit_us));
    program_reg(csma_pkg::REG_CCA_TIME,     32'(c.cca_time_us));
    program_reg(csma_pkg::REG_BYTE_TIME,    32'(c.byte_time_us));
    program_reg(csma_pkg::REG_ACK_WAIT,     32'(c.ack_wait_us));
  endtask

  task automatic start_phase(input int unsigned sidle, input int unsigned rstall,
                             input int unsigned hold);
    @(posedge clk_i);
    idle_pct  = sidle;
    stall_pct = rstall;
    hold_left = hold;
    @(negedge clk_i);
  endtask

  task automatic send_beat(input csma_pkg::in_t b, input bit known,
                           input csma_pkg::out_t want);
    while ($urandom_range(99) < idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push      = 1'b1;
    beat_in   = b;
    lit_known = known;
    lit_want  = want;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n, input int unsigned busy_pct,
                            input int unsigned ack_pct);
    csma_pkg::in_t b;
    for (int i = 0; i < n; i++) begin
      b.backoff_draw = 8'($urandom_range(255));
      b.channel_busy = ($urandom_range(99) < busy_pct);
      b.ack_lost     = ($urandom_range(99) < ack_pct);
      case ($urandom_range(9))
        0:       b.packet_size = 7'd0;
        1:       b.packet_size = 7'd127;
        default: b.packet_size = 7'($urandom_range(127));
      endcase
      send_beat(b, 1'b0, NoRes);
    end
  endtask

  // Returns with the block idle: all results in and trailing beats absorbed.
  task automatic settle();
    push      = 1'b0;
    lit_known = 1'b0;
    while (latency_reports_due.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_time();
    case ($urandom_range(4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin
    csma_pkg::cfg_t c;
    cfg_sh = '{min_backoff_exp: 4'd3, max_backoff_exp: 4'd5, max_csma_backoffs: 3'd4,
               max_frame_retries: 3'd3, backoff_unit_us: 16'd320, cca_time_us: 16'd128,
               byte_time_us: 8'd32, ack_wait_us: 16'd864};
    acc_be    = cfg_sh.min_backoff_exp;
    acc_busy  = '0;
    acc_retry = '0;
    acc_us    = '0;
    acc_open  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    start_phase(0, 0, 0);
    foreach (DirTable[i]) send_beat(DirTable[i].beat, DirTable[i].known, DirTable[i].want);
    settle();

    load_cfg('{min_backoff_exp: 4'd8, max_backoff_exp: 4'd8, max_csma_backoffs: 3'd7,
               max_frame_retries: 3'd7, backoff_unit_us: 16'hFFFF, cca_time_us: 16'hFFFF,
               byte_time_us: 8'hFF, ack_wait_us: 16'hFFFF});
    start_phase(0, 0, 0);
    run_random(120, 40, 40);
    settle();

    load_cfg('0);
    start_phase(67, 0, 0);
    run_random(120, 30, 30);
    settle();

    load_cfg('{min_backoff_exp: 4'd8, max_backoff_exp: 4'd2, max_csma_backoffs: 3'd2,
               max_frame_retries: 3'd1, backoff_unit_us: 16'd1, cca_time_us: 16'd0,
               byte_time_us: 8'd1, ack_wait_us: 16'd0});
    start_phase(0, 67, 0);
    run_random(120, 50, 30);
    settle();

    // Every beat ends a packet while the receiver holds off, so full must rise.
    load_cfg('{min_backoff_exp: 4'd3, max_backoff_exp: 4'd5, max_csma_backoffs: 3'd4,
               max_frame_retries: 3'd3, backoff_unit_us: 16'd320, cca_time_us: 16'd128,
               byte_time_us: 8'd32, ack_wait_us: 16'd864});
    start_phase(0, 0, 80);
    run_random(24, 0, 0);
    settle();

    for (int p = 0; p < 8; p++) begin
      c.min_backoff_exp   = 4'($urandom_range(8));
      c.max_backoff_exp   = 4'($urandom_range(8));
      c.max_csma_backoffs = 3'($urandom_range(7));
      c.max_frame_retries = 3'($urandom_range(7));
      c.backoff_unit_us   = pick_time();
      c.cca_time_us       = pick_time();
      c.byte_time_us      = 8'($urandom_range(255));
      c.ack_wait_us       = pick_time();
      load_cfg(c);
      case (p % 4)
        0:       start_phase(0, 0, 0);
        1:       start_phase(67, 0, 0);
        2:       start_phase(0, 67, 0);
        default: start_phase(28, 28, 0);
      endcase
      run_random(130, $urandom_range(70, 10), $urandom_range(60, 10));
      settle();
    end

    if (fails == 0 && latency_reports_due.size() == 0) begin
      $display("csma_ca_retry_latency: match");
    end else begin
      $display("csma_ca_retry_latency: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("csma_ca_retry_latency: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/csma_pkg.sv
rtl/core/csma_front.sv
rtl/core/csma_back.sv
rtl/core/csma_outq.sv
rtl/core/csma_ca_retry_latency.sv
verif/csma_ca_retry_latency_test.sv
